[rtl/core/lnr_pkg.sv]
package lnr_pkg;

	localparam int LANES      = 16;
	localparam int QUADS      = LANES / 4;
	localparam int XW         = 8;
	localparam int QUAD_W     = XW + 2;
	localparam int SUM_W      = XW + 4;
	localparam int D_W        = SUM_W + 1;
	localparam int M_W        = SUM_W;
	localparam int SQ_W       = 2 * M_W;
	localparam int SQ_QUAD_W  = SQ_W + 2;
	localparam int SQSUM_W    = SQ_W + 5;
	localparam int EPS_W      = 12;
	localparam int NUM3_W     = SQ_W + EPS_W;
	localparam int OUT_SHIFT  = 12;
	localparam int NUM_W      = NUM3_W + OUT_SHIFT;
	localparam int DEN_W      = SQSUM_W + EPS_W;
	localparam int ROOT_STEPS = 7;
	localparam int Q_W        = ROOT_STEPS;
	localparam int QD_W       = DEN_W + Q_W;
	localparam int CAND_W     = NUM_W + 8;
	localparam int DEPTH      = 6 + ROOT_STEPS;

	localparam logic [EPS_W-1:0] EPS_DEN = EPS_W'(3125);
	localparam logic [7:0]       EPS_NUM = 8'd128;

	typedef logic signed [XW-1:0] elem_t;
	typedef logic [SQ_W-1:0]      sq_t;
	typedef logic [NUM3_W-1:0]    num3_t;
	typedef logic [DEN_W-1:0]     den_t;

endpackage

[rtl/core/lnr_lane.sv]
module lnr_lane
	import lnr_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  elem_t                   x,
	input  logic signed [SUM_W-1:0] s,
	output sq_t                     m2,
	output num3_t                   num,
	output logic                    neg
);

	logic signed [D_W-1:0] d;
	logic [M_W-1:0]        m;
	sq_t                   m2_s3;
	logic                  neg_s3, neg_s4, neg_s5, neg_s6;
	num3_t                 num_s4, num_s5, num_s6;

	always_comb begin
		d = (D_W'(x) <<< 4) - D_W'(s);
		m = d[D_W-1] ? M_W'(-d) : M_W'(d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m2_s3  <= SQ_W'(m) * SQ_W'(m);
			neg_s3 <= d[D_W-1];
			num_s4 <= NUM3_W'(m2_s3) * NUM3_W'(EPS_DEN);
			neg_s4 <= neg_s3;
			num_s5 <= num_s4;
			neg_s5 <= neg_s4;
			num_s6 <= num_s5;
			neg_s6 <= neg_s5;
		end
	end

	assign m2  = m2_s3;
	assign num = num_s6;
	assign neg = neg_s6;

endmodule

[rtl/core/lnr_merge.sv]
module lnr_merge
	import lnr_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  sq_t  m2 [LANES],
	output den_t den,
	output logic flat
);

	logic [SQ_QUAD_W-1:0] quad_s4 [QUADS];
	logic [SQSUM_W-1:0]   sq_s5;
	den_t                 den_s6;
	logic                 flat_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < QUADS; g++) begin
				quad_s4[g] <= SQ_QUAD_W'(m2[4*g]) + SQ_QUAD_W'(m2[4*g+1])
					+ SQ_QUAD_W'(m2[4*g+2]) + SQ_QUAD_W'(m2[4*g+3]);
			end
			sq_s5   <= SQSUM_W'(quad_s4[0]) + SQSUM_W'(quad_s4[1])
				+ SQSUM_W'(quad_s4[2]) + SQSUM_W'(quad_s4[3]);
			den_s6  <= DEN_W'(sq_s5) * DEN_W'(EPS_DEN) + DEN_W'(EPS_NUM);
			flat_s6 <= (sq_s5 == '0);
		end
	end

	assign den  = den_s6;
	assign flat = flat_s6;

endmodule

[rtl/core/lnr_bisect.sv]
module lnr_bisect
	import lnr_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  num3_t      num,
	input  logic       neg,
	input  den_t       den [ROOT_STEPS],
	output logic [7:0] res
);

	logic [NUM_W-1:0] p_q   [ROOT_STEPS+1];
	logic [QD_W-1:0]  qd_q  [ROOT_STEPS+1];
	logic [Q_W-1:0]   q_q   [ROOT_STEPS+1];
	logic [NUM_W-1:0] num_q [ROOT_STEPS+1];
	logic             neg_q [ROOT_STEPS+1];

	assign p_q[0]   = '0;
	assign qd_q[0]  = '0;
	assign q_q[0]   = '0;
	assign num_q[0] = {num, OUT_SHIFT'(0)};
	assign neg_q[0] = neg;

	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
		localparam int K = ROOT_STEPS - 1 - j;
		logic [CAND_W-1:0] cand;
		logic              take;

		always_comb begin
			cand = CAND_W'(p_q[j]) + (CAND_W'(qd_q[j]) << (K + 1))
				+ (CAND_W'(den[j]) << (2 * K));
			take = cand <= CAND_W'(num_q[j]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_q[j+1]   <= take ? NUM_W'(cand) : p_q[j];
				qd_q[j+1]  <= take ? qd_q[j] + (QD_W'(den[j]) << K) : qd_q[j];
				q_q[j+1]   <= take ? (q_q[j] | (Q_W'(1) << K)) : q_q[j];
				num_q[j+1] <= num_q[j];
				neg_q[j+1] <= neg_q[j];
			end
		end
	end

	always_comb begin
		if (neg_q[ROOT_STEPS]) res = 8'(-{1'b0, q_q[ROOT_STEPS]});
		else res = {1'b0, q_q[ROOT_STEPS]};
	end

endmodule

[rtl/core/layer_norm_int8_row.sv]
// channel  | group               | contents
// input    | s_tvalid/s_tready   | s_tdata[127:0]: row_low_bytes, row_high_bytes
// output   | m_tvalid/m_tready   | m_tdata[127:0]: norm_low_bytes, norm_high_bytes;
//          |                     | m_tuser[0]: flat_row
// One row per cycle sustained while no result is held, through a 13-stage pipeline
// (two stages row sum, one lane square, two square-sum tree, one denominator
// scale, seven reciprocal-root bisection steps in every lane).
// Reset clears only the stage valid bits.
// A held result stalls every stage at once; s_tready is low only then.
module layer_norm_int8_row
	import lnr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // row_low_bytes, row_high_bytes
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // norm_low_bytes, norm_high_bytes
	output logic [0:0]   m_tuser   // flat_row
);

	logic                    en;
	logic [DEPTH-1:0]        v_q;
	elem_t                   x_s1 [LANES];
	elem_t                   x_s2 [LANES];
	logic signed [QUAD_W-1:0] quad_s1 [QUADS];
	logic signed [SUM_W-1:0] s_s2;
	sq_t                     m2 [LANES];
	num3_t                   num [LANES];
	logic                    neg [LANES];
	den_t                    den_m;
	logic                    flat_m;
	den_t                    den_q [1:ROOT_STEPS-1];
	logic                    flat_q [1:ROOT_STEPS];
	den_t                    den_pipe [ROOT_STEPS];
	logic [7:0]              res [LANES];

	assign en       = !v_q[DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_q[DEPTH-1];
	assign m_tuser  = flat_q[ROOT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[DEPTH-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				x_s1[i] <= elem_t'(s_tdata[8*i +: 8]);
				x_s2[i] <= x_s1[i];
			end
			for (int g = 0; g < QUADS; g++) begin
				quad_s1[g] <= QUAD_W'(elem_t'(s_tdata[32*g +: 8]))
					+ QUAD_W'(elem_t'(s_tdata[32*g+8 +: 8]))
					+ QUAD_W'(elem_t'(s_tdata[32*g+16 +: 8]))
					+ QUAD_W'(elem_t'(s_tdata[32*g+24 +: 8]));
			end
			s_s2 <= SUM_W'(quad_s1[0]) + SUM_W'(quad_s1[1])
				+ SUM_W'(quad_s1[2]) + SUM_W'(quad_s1[3]);
			den_q[1] <= den_m;
			for (int j = 2; j < ROOT_STEPS; j++) begin
				den_q[j] <= den_q[j-1];
			end
			flat_q[1] <= flat_m;
			for (int j = 2; j <= ROOT_STEPS; j++) begin
				flat_q[j] <= flat_q[j-1];
			end
		end
	end

	always_comb begin
		den_pipe[0] = den_m;
		for (int j = 1; j < ROOT_STEPS; j++) begin
			den_pipe[j] = den_q[j];
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		lnr_lane u_lane (
			.clk (clk),
			.en  (en),
			.x   (x_s2[i]),
			.s   (s_s2),
			.m2  (m2[i]),
			.num (num[i]),
			.neg (neg[i])
		);

		lnr_bisect u_bisect (
			.clk (clk),
			.en  (en),
			.num (num[i]),
			.neg (neg[i]),
			.den (den_pipe),
			.res (res[i])
		);

		assign m_tdata[8*i +: 8] = res[i];
	end

	lnr_merge u_merge (
		.clk  (clk),
		.en   (en),
		.m2   (m2),
		.den  (den_m),
		.flat (flat_m)
	);

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("flat row with nonzero data");

	a_no_min_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] != 8'h80 && m_tdata[127:120] != 8'h80)
		else $error("normalized byte out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !v_q[DEPTH-2] |=> !m_tvalid)
		else $error("result repeated");

endmodule
